// ===== rtl/teenum_pkg.sv =====
// teenum_pkg: shared types and constants for the tetrahedral edge enumerator
// no dependencies
package teenum_pkg;
  localparam int VID_W    = 10;
  localparam int EID_W    = 13;
  localparam int CNT_W    = 14;
  localparam int EDGES    = 6;
  localparam int VERTS    = 4;

  typedef struct packed {
    logic [VID_W-1:0] vertex_a;
    logic [VID_W-1:0] vertex_b;
    logic [VID_W-1:0] vertex_c;
    logic [VID_W-1:0] vertex_d;
  } tet_t;

  typedef struct packed {
    logic [EID_W-1:0] edge_id_ab;
    logic [EID_W-1:0] edge_id_ac;
    logic [EID_W-1:0] edge_id_ad;
    logic [EID_W-1:0] edge_id_bc;
    logic [EID_W-1:0] edge_id_bd;
    logic [EID_W-1:0] edge_id_cd;
    logic [EDGES-1:0] new_edge_mask;
    logic [CNT_W-1:0] edges_so_far;
    logic             overflow;
  } res_t;

  // one sorted edge handed from the front end to the back end
  typedef struct packed {
    logic [VID_W-1:0] lo;
    logic [VID_W-1:0] hi;
    logic             last;
  } edge_t;
endpackage

// ===== rtl/teenum_if.sv =====
// teenum_if: valid/ready channel carrying a generic payload type
// no dependencies
interface teenum_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tetra_edge_enumerator_top.sv =====
// tetra edge enumerator: one tetrahedron in, an edge id for each of its edges out
// each edge is looked up by a sequential scan of the adjacency list of its lower vertex;
// a hit ends its scan early, a miss inserts the edge if there is room
// results are paced by the sequential scan of each adjacency list in the back end;
// the edge queue lets the front run ahead
// reset: synchronous active low; then a clearing pass zeroes all MAX_VERTICES degree ram entries
module tetra_edge_enumerator_top #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_DEGREE   = 16,
  parameter int MAX_EDGES    = 8192
) (
  input logic clk,
  input logic rst_n,
  teenum_if.sink   in_ch,
  teenum_if.source out_ch
);
  import teenum_pkg::*;
  logic  q_valid, q_pop;
  edge_t q_edge;
  res_t  res;

  teenum_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_tet(in_ch.data),
    .q_valid, .q_pop, .q_edge);
  teenum_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE),
    .MAX_EDGES(MAX_EDGES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_edge,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res));
  assign out_ch.data = res;

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_ovf_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && res.edges_so_far == '0 |-> res.new_edge_mask == '0)
    else $error("new edge with zero count");
`endif
endmodule

// ===== rtl/teenum_ram.sv =====
// teenum_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module teenum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/teenum_front.sv =====
// teenum_front: accepts tetrahedra, sorts each of their edges into a queue
// depends on teenum_pkg
module teenum_front #(
  parameter int QDEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  teenum_pkg::tet_t    in_tet,
  output logic                q_valid,
  input  logic                q_pop,
  output teenum_pkg::edge_t   q_edge
);
  import teenum_pkg::*;
  localparam int QA = $clog2(QDEPTH);

  tet_t          tet_r;
  logic          busy_r;
  logic [2:0]    eidx_r;
  edge_t         q_mem [QDEPTH];
  logic [QA-1:0] wp_r, rp_r;
  logic [QA:0]   cnt_r;
  logic [VID_W-1:0] x, y;
  logic          push;

  assign in_ready = !busy_r;
  always_comb begin
    case (eidx_r)
      3'd0: begin x = tet_r.vertex_a; y = tet_r.vertex_b; end
      3'd1: begin x = tet_r.vertex_a; y = tet_r.vertex_c; end
      3'd2: begin x = tet_r.vertex_a; y = tet_r.vertex_d; end
      3'd3: begin x = tet_r.vertex_b; y = tet_r.vertex_c; end
      3'd4: begin x = tet_r.vertex_b; y = tet_r.vertex_d; end
      default: begin x = tet_r.vertex_c; y = tet_r.vertex_d; end
    endcase
  end
  assign push = busy_r && (cnt_r != (QA+1)'(QDEPTH));
  assign q_valid = cnt_r != '0;
  assign q_edge  = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) tet_r <= in_tet;
    if (push) begin
      q_mem[wp_r].lo   <= (x < y) ? x : y;
      q_mem[wp_r].hi   <= (x < y) ? y : x;
      q_mem[wp_r].last <= eidx_r == 3'(EDGES-1);
    end
    if (!rst_n) begin
      busy_r <= 1'b0; eidx_r <= '0; wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (in_valid && in_ready) busy_r <= 1'b1;
      if (push) begin
        wp_r <= wp_r + 1'b1;
        if (eidx_r == 3'(EDGES-1)) begin
          eidx_r <= '0; busy_r <= 1'b0;
        end else eidx_r <= eidx_r + 3'd1;
      end
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QA+1)'(push) - (QA+1)'(q_pop);
    end
  end
endmodule

// ===== rtl/teenum_back.sv =====
// teenum_back: per-edge lookup/insert over the adjacency rams, builds results
// depends on teenum_pkg, teenum_ram
module teenum_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_DEGREE   = 16,
  parameter int MAX_EDGES    = 8192
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  teenum_pkg::edge_t q_edge,
  output logic              out_valid,
  input  logic              out_ready,
  output teenum_pkg::res_t  out_res
);
  import teenum_pkg::*;
  localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DA = $clog2(MAX_DEGREE);
  localparam int DW = $clog2(MAX_DEGREE+1);
  localparam int SD = MAX_VERTICES * MAX_DEGREE;
  localparam int SA = $clog2(SD);
  localparam int CW = $clog2(MAX_EDGES+1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_SCAN, S_WR, S_OUT} st_t;
  st_t st_r;

  logic [VA-1:0]  clr_r;
  logic [VID_W-1:0] lo_r, hi_r;
  logic           last_r, lo_ok_r;
  logic [DW-1:0]  deg_r;
  logic [DW-1:0]  sidx_r;
  logic [CW-1:0]  next_r;
  logic [2:0]     e_r;
  logic [EID_W-1:0] ids_r [EDGES];
  logic [EDGES-1:0] mask_r;
  logic           ovf_r;

  // degree ram
  logic          deg_we;
  logic [VA-1:0] deg_wa, deg_ra;
  logic [DW-1:0] deg_wd, deg_rd;
  // neighbor and edge id rams
  logic          st_we;
  logic [SA-1:0] st_wa, st_ra;
  logic [VID_W-1:0] nb_rd;
  logic [EID_W-1:0] ei_rd;

  teenum_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg (
    .clk, .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
  teenum_ram #(.WIDTH(VID_W), .DEPTH(SD)) u_nb (
    .clk, .we(st_we), .waddr(st_wa), .wdata(hi_r), .raddr(st_ra), .rdata(nb_rd));
  teenum_ram #(.WIDTH(EID_W), .DEPTH(SD)) u_ei (
    .clk, .we(st_we), .waddr(st_wa), .wdata(EID_W'(next_r)), .raddr(st_ra),
    .rdata(ei_rd));

  logic lo_ok;
  assign lo_ok = 32'(q_edge.lo) < MAX_VERTICES;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign deg_ra = VA'(q_edge.lo);
  // scan address: one entry per cycle
  assign st_ra = SA'(VA'(lo_r)) * SA'(MAX_DEGREE) + SA'(sidx_r[DA-1:0]);
  assign st_wa = SA'(VA'(lo_r)) * SA'(MAX_DEGREE) + SA'(deg_r[DA-1:0]);
  logic can_ins;
  assign can_ins = lo_ok_r && (deg_r < DW'(MAX_DEGREE)) && (next_r < CW'(MAX_EDGES));
  assign st_we  = (st_r == S_WR) && can_ins;
  assign deg_we = (st_r == S_CLEAR) || st_we;
  assign deg_wa = (st_r == S_CLEAR) ? clr_r : VA'(lo_r);
  assign deg_wd = (st_r == S_CLEAR) ? '0 : deg_r + 1'b1;

  // scan hit: entry read last cycle (sidx_r-1) matched
  logic hit;
  assign hit = (st_r == S_SCAN) && (nb_rd == hi_r);

  assign out_valid = st_r == S_OUT;
  assign out_res.edge_id_ab = ids_r[0];
  assign out_res.edge_id_ac = ids_r[1];
  assign out_res.edge_id_ad = ids_r[2];
  assign out_res.edge_id_bc = ids_r[3];
  assign out_res.edge_id_bd = ids_r[4];
  assign out_res.edge_id_cd = ids_r[5];
  assign out_res.new_edge_mask = mask_r;
  assign out_res.edges_so_far = CNT_W'(next_r);
  assign out_res.overflow = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; next_r <= '0; e_r <= '0;
      mask_r <= '0; ovf_r <= 1'b0;
    end else begin
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_VERTICES-1) st_r <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          lo_r <= q_edge.lo; hi_r <= q_edge.hi; last_r <= q_edge.last;
          lo_ok_r <= lo_ok; sidx_r <= '0;
          st_r <= S_RD;
        end
        S_RD: begin
          deg_r <= lo_ok_r ? deg_rd : '0;
          // degree entries are at most MAX_DEGREE
          if (!lo_ok_r || deg_rd == '0) st_r <= S_WR;
          else begin sidx_r <= DW'(1); st_r <= S_SCAN; end
        end
        S_SCAN: begin
          if (hit) begin
            ids_r[e_r] <= ei_rd;
            if (last_r) st_r <= S_OUT;
            else begin e_r <= e_r + 3'd1; st_r <= S_IDLE; end
          end else if (sidx_r == deg_r) st_r <= S_WR;
          else sidx_r <= sidx_r + 1'b1;
        end
        S_WR: begin
          if (can_ins) begin
            ids_r[e_r] <= EID_W'(next_r);
            mask_r[e_r] <= 1'b1;
            next_r <= next_r + 1'b1;
          end else begin
            ids_r[e_r] <= '0; ovf_r <= 1'b1;
          end
          if (last_r) st_r <= S_OUT;
          else begin e_r <= e_r + 3'd1; st_r <= S_IDLE; end
        end
        S_OUT: if (out_ready) begin
          st_r <= S_IDLE; e_r <= '0; mask_r <= '0; ovf_r <= 1'b0;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sim/tb_top.sv =====
// tb_top: testbench for tetra_edge_enumerator_top
// drives tetrahedra over teenum_if, predicts edge ids with its own adjacency
// tables and checks each result transfer; depends on teenum_pkg, teenum_if and tetra_edge_enumerator_top
`timescale 1ns / 100ps

module tb_top;
  import teenum_pkg::*;

  localparam int NVERT = 1024;
  localparam int NDEG  = 16;
  localparam int NEDGE = 8192;

  logic clk;
  logic rst_n;
  int   err_cnt;

  teenum_if #(.payload_t(tet_t)) in_ch (clk);
  teenum_if #(.payload_t(res_t)) out_ch (clk);

  tetra_edge_enumerator_top #(
    .MAX_VERTICES(NVERT), .MAX_DEGREE(NDEG), .MAX_EDGES(NEDGE)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state: per-vertex adjacency lists
  logic [4:0]       adj_count [NVERT];
  logic [VID_W-1:0] adj_vertex [NVERT][NDEG];
  logic [EID_W-1:0] adj_edge [NVERT][NDEG];
  logic [CNT_W-1:0] edge_total;
  res_t             expected_q[$];
  int               sent_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("tb_top: errors");
    $finish;
  end

  // look up or insert one edge; returns 0 when it could not be stored
  function automatic bit enumerate_edge(input logic [VID_W-1:0] x, input logic [VID_W-1:0] y,
                                        output logic [EID_W-1:0] id, output bit fresh);
    logic [VID_W-1:0] lo;
    logic [VID_W-1:0] hi;
    int n;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    id = '0;
    fresh = 1'b0;
    n = int'(adj_count[lo]);
    for (int i = 0; i < n; i++) begin
      if (adj_vertex[lo][i] == hi) begin
        id = adj_edge[lo][i];
        return 1'b1;
      end
    end
    if (n >= NDEG || edge_total >= NEDGE) return 1'b0;
    adj_vertex[lo][n] = hi;
    adj_edge[lo][n] = edge_total[EID_W-1:0];
    adj_count[lo] = 5'(n + 1);
    id = edge_total[EID_W-1:0];
    edge_total++;
    fresh = 1'b1;
    return 1'b1;
  endfunction

  function automatic res_t predict_edges(input tet_t t);
    res_t r;
    logic [VID_W-1:0] v[VERTS];
    logic [EID_W-1:0] ids[EDGES];
    int lo_idx[EDGES] = '{0, 0, 0, 1, 1, 2};
    int hi_idx[EDGES] = '{1, 2, 3, 2, 3, 3};
    bit fresh;
    v = '{t.vertex_a, t.vertex_b, t.vertex_c, t.vertex_d};
    r = '0;
    for (int e = 0; e < EDGES; e++) begin
      if (!enumerate_edge(v[lo_idx[e]], v[hi_idx[e]], ids[e], fresh)) r.overflow = 1'b1;
      if (fresh) r.new_edge_mask[e] = 1'b1;
    end
    r.edge_id_ab = ids[0];
    r.edge_id_ac = ids[1];
    r.edge_id_ad = ids[2];
    r.edge_id_bc = ids[3];
    r.edge_id_bd = ids[4];
    r.edge_id_cd = ids[5];
    r.edges_so_far = edge_total;
    return r;
  endfunction

  // valid stays high after a transfer unless an idle gap follows
  task automatic send_tet(input logic [VID_W-1:0] a, b, c, d);
    tet_t t;
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    t = '{a, b, c, d};
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_edges(t));
    sent_cnt++;
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // result side: random stall, then compare each transfer
  initial begin
    res_t exp_r;
    res_t got;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = out_ch.data;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        err_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_tet(0, 1, 2, 3);
    send_tet(3, 2, 1, 0);          // all edges already known
    send_tet(1023, 1022, 1021, 1020);
    send_tet(5, 5, 5, 5);          // repeated vertices, self edge
    send_tet(7, 7, 8, 8);
    send_tet(10'h155, 10'h2aa, 0, 1023);
    send_tet(1023, 1023, 0, 0);
    // fill the list of vertex 100 past its capacity
    for (int i = 0; i < 6; i++) begin
      send_tet(100, VID_W'(101 + 3*i), VID_W'(102 + 3*i), VID_W'(103 + 3*i));
    end
  endtask

  // mostly reuse a small vertex pool so lookups hit and lists fill
  task automatic test_random(input int count);
    logic [VID_W-1:0] v[VERTS];
    int pool;
    for (int n = 0; n < count; n++) begin
      pool = (n % 400 < 300) ? 63 : 1023;
      foreach (v[i]) v[i] = VID_W'($urandom_range(0, pool));
      if (n == count / 2) wait_drain();
      send_tet(v[0], v[1], v[2], v[3]);
    end
  endtask

  // push edge ids to exhaustion with random vertices
  task automatic test_exhaust();
    logic [VID_W-1:0] v[VERTS];
    while (edge_total < NEDGE) begin
      foreach (v[i]) v[i] = VID_W'($urandom_range(0, NVERT-1));
      send_tet(v[0], v[1], v[2], v[3]);
    end
    repeat (20) begin
      foreach (v[i]) v[i] = VID_W'($urandom_range(0, NVERT-1));
      send_tet(v[0], v[1], v[2], v[3]);
    end
  endtask

  initial begin
    err_cnt = 0;
    sent_cnt = 0;
    edge_total = '0;
    foreach (adj_count[i]) adj_count[i] = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(400);
    test_exhaust();
    wait_drain();
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
